/* rtl/isg_pkg.sv */
// shared constants, config register codes and the mod-251 reduction for the share generator
// no dependencies
`default_nettype none

package isg_pkg;

  localparam int PIX_W     = 8;
  localparam int VAL_W     = 8;
  localparam int IDX_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 16;

  localparam int MAX_SHARES_DEF    = 16;
  localparam int MAX_THRESHOLD_DEF = 16;

  localparam logic [VAL_W-1:0] PRIME       = 8'd251;
  localparam logic [PIX_W-1:0] PIXEL_CLAMP = 8'd250;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 5'd2;
  localparam logic [CFG_W-1:0] SHARES_RST    = 5'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARES    = 2'd1;

  // 256 = 5 mod 251, so fold the high byte twice and finish with one subtract
  function automatic logic [VAL_W-1:0] mod251(input logic [PROD_W-1:0] v);
    logic [10:0] s1;
    logic [8:0]  s2;
    s1 = 11'(v[15:8]) * 11'd5 + 11'(v[7:0]);
    s2 = 9'(s1[10:8]) * 9'd5 + 9'(s1[7:0]);
    if (s2 >= 9'(PRIME)) begin
      s2 = s2 - 9'(PRIME);
    end
    return s2[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/isg_mulmod.sv */
// shared multiply-add unit: registers a*x+p, then reduces mod 251
// depends on isg_pkg
`default_nettype none

module isg_mulmod (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [isg_pkg::VAL_W-1:0] a_i,
  input  wire logic [isg_pkg::VAL_W-1:0] x_i,
  input  wire logic [isg_pkg::PIX_W-1:0] p_i,
  output      logic [isg_pkg::VAL_W-1:0] res_o
);
  import isg_pkg::*;

  logic [PROD_W-1:0] prod_d, prod_q;

  // max 250*250+250 fits in 16 bits
  assign prod_d = PROD_W'(a_i) * PROD_W'(x_i) + PROD_W'(p_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign res_o = mod251(prod_q);

endmodule

`default_nettype wire

/* rtl/isg_acc_mem.sv */
// accumulator store, one entry per share point, single port with registered read
// depends on isg_pkg
`default_nettype none

module isg_acc_mem #(
  parameter int DEPTH = isg_pkg::MAX_SHARES_DEF,
  parameter int AW    = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AW-1:0]             addr_i,
  input  wire logic [isg_pkg::VAL_W-1:0] wdata_i,
  output      logic [isg_pkg::VAL_W-1:0] rdata_o
);
  import isg_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/image_share_generator_mod251_unit.sv */
// Threshold secret image share generator over GF(251). Each accepted pixel is clamped to 250
// and folded into one Horner accumulator per share point x = 1..MAX_SHARES through a single
// shared multiply-add-mod-251 unit; every point steps through accumulator read, multiply, and
// reduce and write back, so in_stall_o stays high from the accepted pixel until the last
// point is written back, and the next pixel is taken once the block is idle again; the pass
// is held while a finished share waits on out_stall_i. The pixel that completes a group of
// threshold_k pixels emits share_count beats on the output during that same pass. The
// accumulator store needs no clearing: the first pixel of each group reads it as zero. Config
// writes are always taken and are meant to happen while the block is idle.
// depends on isg_pkg, isg_mulmod, isg_acc_mem
`default_nettype none

module image_share_generator_mod251_unit #(
  parameter int MAX_SHARES    = isg_pkg::MAX_SHARES_DEF,
  parameter int MAX_THRESHOLD = isg_pkg::MAX_THRESHOLD_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [isg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [isg_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel in
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [isg_pkg::PIX_W-1:0]     pixel_i,
  // shares out
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [isg_pkg::IDX_W-1:0]     share_index_o,
  output      logic [isg_pkg::VAL_W-1:0]     share_value_o,
  output      logic                          last_o
);
  import isg_pkg::*;

  localparam int AW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
  localparam int XW = $clog2(MAX_SHARES + 1);
  localparam int NW = (XW > CFG_W) ? XW : CFG_W;
  localparam int KW = $clog2(MAX_THRESHOLD + 1);
  localparam int CW = (KW > CFG_W) ? KW : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_RED  = 4'b1000
  } state_e;

  state_e state_d, state_q;

  logic [CFG_W-1:0] thr_q, shr_q;
  logic [KW-1:0]    cnt_d, cnt_q, cnt_inc;
  logic [AW-1:0]    idx_d, idx_q;
  logic [PIX_W-1:0] p_q;
  logic             complete_q, first_q;
  logic             complete_d, first_d;

  logic [CW-1:0] eff_k;
  logic [NW-1:0] eff_n;
  logic [XW-1:0] x_w;
  logic          accept, emit, is_last, done, out_free, step;

  logic [VAL_W-1:0] rdata, acc_a, res;

  logic             out_valid_d, out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      shr_q <= SHARES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_SHARES:    shr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (thr_q == '0) begin
      eff_k = CW'(1);
    end else if (CW'(thr_q) > CW'(MAX_THRESHOLD)) begin
      eff_k = CW'(MAX_THRESHOLD);
    end else begin
      eff_k = CW'(thr_q);
    end
    if (shr_q == '0) begin
      eff_n = NW'(1);
    end else if (NW'(shr_q) > NW'(MAX_SHARES)) begin
      eff_n = NW'(MAX_SHARES);
    end else begin
      eff_n = NW'(shr_q);
    end
  end

  // input side
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign cnt_inc = (cnt_q == KW'(MAX_THRESHOLD)) ? cnt_q : cnt_q + KW'(1);

  // sequencer over share points
  assign x_w      = XW'(idx_q) + XW'(1);
  assign emit     = complete_q && (NW'(x_w) <= eff_n);
  assign is_last  = (NW'(x_w) == eff_n);
  assign done     = (idx_q == AW'(MAX_SHARES - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = (state_q == S_RED) && (!emit || out_free);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    complete_d = complete_q;
    first_d    = first_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          complete_d = (CW'(cnt_inc) >= eff_k);
          first_d    = (cnt_q == '0);
          cnt_d      = (CW'(cnt_inc) >= eff_k) ? '0 : cnt_inc;
          idx_d      = '0;
          state_d    = S_READ;
        end
      end
      S_READ: state_d = S_MUL;
      S_MUL:  state_d = S_RED;
      S_RED: begin
        if (step) begin
          if (done) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      complete_q <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      complete_q <= complete_d;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= (pixel_i > PIXEL_CLAMP) ? PIXEL_CLAMP : pixel_i;
    end
  end

  // first pixel of a group starts from a zero accumulator
  assign acc_a = first_q ? '0 : rdata;

  isg_acc_mem #(
    .DEPTH (MAX_SHARES),
    .AW    (AW)
  ) u_acc_mem (
    .clk_i   (clk_i),
    .rd_en_i (state_q == S_READ),
    .wr_en_i (step),
    .addr_i  (idx_q),
    .wdata_i (res),
    .rdata_o (rdata)
  );

  isg_mulmod u_mulmod (
    .clk_i (clk_i),
    .en_i  (state_q == S_MUL),
    .a_i   (acc_a),
    .x_i   (VAL_W'(x_w)),
    .p_i   (p_q),
    .res_o (res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (step && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_idx_q  <= IDX_W'(x_w);
      out_val_q  <= res;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign share_index_o = out_idx_q;
  assign share_value_o = out_val_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
